FILE: rtl/core/rbd_pkg.sv
package rbd_pkg;

    localparam int unsigned WORD_W  = 36;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned TYPE_W  = 7;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned ADDR_W  = 18;

    // Header word layout
    localparam int unsigned EOF_BIT    = 35;
    localparam int unsigned CODE_LSB   = 32;
    localparam int unsigned TYPE_LSB   = 25;
    localparam int unsigned COUNT_LSB  = 18;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER    = 3'd0,
        KIND_DATA      = 3'd1,
        KIND_SUM_GOOD  = 3'd2,
        KIND_SUM_BAD   = 3'd3,
        KIND_TRUNCATED = 3'd4,
        KIND_STREAM_END = 3'd5
    } kind_t;

    // Framer phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_DATA   = 3'b010,
        PH_CHECK  = 3'b100
    } phase_t;

    typedef struct packed {
        kind_t                kind;
        logic [WORD_W-1:0]    word_out;
        logic                 eof_flag;
        logic [CODE_W-1:0]    loader_code;
        logic [TYPE_W-1:0]    block_type;
        logic [COUNT_W-1:0]   word_count;
        logic [ADDR_W-1:0]    block_address;
        logic [COUNT_W-1:0]   data_index;
        logic [WORD_W-1:0]    expected_sum;
    } result_t;

    // Output queue occupancy
    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } oq_status_t;

endpackage

FILE: rtl/core/rbd_in_if.sv
interface rbd_in_if;
    import rbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_in;
    logic              end_of_input;

    modport source (output valid, output word_in, output end_of_input, input ready);
    modport sink   (input valid, input word_in, input end_of_input, output ready);
endinterface

FILE: rtl/core/rbd_out_if.sv
interface rbd_out_if;
    import rbd_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [WORD_W-1:0]  word_out;
    logic               eof_flag;
    logic [CODE_W-1:0]  loader_code;
    logic [TYPE_W-1:0]  block_type;
    logic [COUNT_W-1:0] word_count;
    logic [ADDR_W-1:0]  block_address;
    logic [COUNT_W-1:0] data_index;
    logic [WORD_W-1:0]  expected_sum;

    modport source (
        output valid, output kind, output word_out, output eof_flag,
        output loader_code, output block_type, output word_count,
        output block_address, output data_index, output expected_sum,
        input ready
    );
    modport sink (
        input valid, input kind, input word_out, input eof_flag,
        input loader_code, input block_type, input word_count,
        input block_address, input data_index, input expected_sum,
        output ready
    );
endinterface

FILE: rtl/core/rbd_frame_ctrl.sv
module rbd_frame_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [rbd_pkg::WORD_W-1:0] word_in,
    input  logic                      end_of_input,
    output rbd_pkg::result_t          result
);
    import rbd_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [WORD_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0]  left_reg, left_next;
    logic [COUNT_W-1:0]  pos_reg, pos_next;

    logic [WORD_W:0]     raw_sum;
    logic [WORD_W-1:0]   eac_sum;
    logic [WORD_W-1:0]   expect_sum;
    logic [COUNT_W-1:0]  hdr_count;
    logic                hdr_eof;

    // End-around carry add of the data word into the running sum
    assign raw_sum    = {1'b0, sum_reg} + {1'b0, word_in};
    assign eac_sum    = raw_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, raw_sum[WORD_W]};
    assign expect_sum = ~sum_reg;
    assign hdr_count  = word_in[COUNT_LSB +: COUNT_W];
    assign hdr_eof    = word_in[EOF_BIT];

    // Result and next state for the current beat
    always_comb
    begin
        result     = '0;
        phase_next = phase_reg;
        sum_next   = sum_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        case (phase_reg)
            PH_DATA:
            begin
                if (end_of_input)
                begin
                    result.kind = KIND_TRUNCATED;
                    phase_next  = PH_HEADER;
                    left_next   = '0;
                    pos_next    = '0;
                end
                else
                begin
                    result.kind       = KIND_DATA;
                    result.word_out   = word_in;
                    result.data_index = pos_reg;
                    sum_next          = eac_sum;
                    pos_next          = pos_reg + COUNT_W'(1);
                    left_next         = left_reg - COUNT_W'(1);
                    if (left_reg == COUNT_W'(1))
                    begin
                        phase_next = PH_CHECK;
                    end
                end
            end
            PH_CHECK:
            begin
                if (end_of_input)
                begin
                    result.kind = KIND_TRUNCATED;
                end
                else
                begin
                    result.kind         = (expect_sum == word_in) ? KIND_SUM_GOOD
                                                                  : KIND_SUM_BAD;
                    result.word_out     = word_in;
                    result.expected_sum = expect_sum;
                end
                phase_next = PH_HEADER;
                left_next  = '0;
                pos_next   = '0;
            end
            default:
            begin
                if (end_of_input)
                begin
                    result.kind = KIND_STREAM_END;
                end
                else
                begin
                    result.kind          = KIND_HEADER;
                    result.word_out      = word_in;
                    result.eof_flag      = hdr_eof;
                    result.loader_code   = word_in[CODE_LSB +: CODE_W];
                    result.block_type    = word_in[TYPE_LSB +: TYPE_W];
                    result.word_count    = hdr_count;
                    result.block_address = word_in[ADDR_W-1:0];
                    sum_next             = word_in;
                    pos_next             = '0;
                    if (hdr_eof || (hdr_count == '0))
                    begin
                        left_next  = '0;
                        phase_next = PH_CHECK;
                    end
                    else
                    begin
                        left_next  = hdr_count;
                        phase_next = PH_DATA;
                    end
                end
            end
        endcase
    end

    // State advances only on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            sum_reg   <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

FILE: rtl/core/rbd_out_stage.sv
module rbd_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rbd_pkg::result_t     push_data,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rbd_pkg::result_t     out_data,
    output rbd_pkg::oq_status_t  status
);
    import rbd_pkg::*;

    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign status    = '{main_valid: main_valid_reg, skid_valid: skid_valid_reg};

    // Main register plus one skid entry
    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

FILE: rtl/core/rel_block_deframer_checksum_unit.sv
// Relocatable-object block deframer with 36-bit ones' complement checksum.
// Channels: "words" carries one 36-bit stream word per beat plus an
// end_of_input flag; "results" carries one decoded result per input beat
// (header fields, data word with index, checksum verdict with expected sum,
// truncation or stream end).
// A result is registered in the output queue when its beat is accepted.
// Throughput: one beat per cycle while the skid entry is free; the decode,
// end-around-carry add and checksum compare feed the queue combinationally.
// Stall: results sit in a two-entry output queue (main register plus skid
// entry). words.ready stays high while the skid entry is free, so one more
// beat is taken while a result waits; with both entries full ready drops
// until the receiver takes a beat.
// Reset (rst_n, async, active low): the framer expects a header, the
// running sum, word counter and data index clear, and the queue empties.
module rel_block_deframer_checksum_unit (
    input  logic     clk,
    input  logic     rst_n,
    rbd_in_if.sink   words,
    rbd_out_if.source results
);
    import rbd_pkg::*;

    logic       accept;
    logic       can_push;
    result_t    ctrl_result;
    result_t    out_data;
    oq_status_t oq_status;

    assign accept      = words.valid && can_push;
    assign words.ready = can_push;

    rbd_frame_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .word_in      (words.word_in),
        .end_of_input (words.end_of_input),
        .result       (ctrl_result)
    );

    rbd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (ctrl_result),
        .can_push  (can_push),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (out_data),
        .status    (oq_status)
    );

    // Unpack the result beat onto the channel
    assign results.kind          = out_data.kind;
    assign results.word_out      = out_data.word_out;
    assign results.eof_flag      = out_data.eof_flag;
    assign results.loader_code   = out_data.loader_code;
    assign results.block_type    = out_data.block_type;
    assign results.word_count    = out_data.word_count;
    assign results.block_address = out_data.block_address;
    assign results.data_index    = out_data.data_index;
    assign results.expected_sum  = out_data.expected_sum;

    // Skid entry is only used behind a full main register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        oq_status.skid_valid |-> oq_status.main_valid)
        else $error("skid entry valid with empty main register");

    // After an accepted beat, a result is valid on the channel next cycle
    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (words.valid && words.ready) |=> results.valid)
        else $error("accepted beat produced no result");

    // A held skid entry is not dropped while the receiver stalls
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (oq_status.skid_valid && !results.ready) |=> oq_status.skid_valid)
        else $error("skid entry lost during stall");

endmodule
